>>> hw/rtl/lexer_longest_token_match_unit_assert.svh
// Assertion macros for the longest token match unit.
// The module that uses them supplies clk and rst_n.
`ifndef LEXER_LONGEST_TOKEN_MATCH_UNIT_ASSERT_SVH
`define LEXER_LONGEST_TOKEN_MATCH_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LLTM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define LLTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define LLTM_ASSERT_SAME(label, ante, cons)
`define LLTM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/lltm_pkg.sv
`default_nettype none

package lltm_pkg;

    localparam int NUM_ENTRIES   = 32;
    localparam int MAX_ENTRY_LEN = 6;
    localparam int FIRST_ID      = 4;
    localparam int IDX_W         = 5;
    localparam int ID_W          = 6;
    localparam int LEN_W         = 3;

    typedef logic [7:0]                   byte_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [LEN_W-1:0]             len_t;
    typedef logic [NUM_ENTRIES-1:0]       match_vec_t;
    typedef logic [8*MAX_ENTRY_LEN-1:0]   text_t;

    // Entry k has token id FIRST_ID + k.
    localparam len_t ENTRY_LEN [NUM_ENTRIES] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3,
        3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5
    };

    // Right-justified text: the last character sits in bits 7:0.
    localparam text_t ENTRY_TEXT [NUM_ENTRIES] = '{
        48'("+"), 48'("-"), 48'("*"), 48'("/"),
        48'("="), 48'("<"), 48'("<="), 48'(">"),
        48'(">="), 48'("=="), 48'("!="), 48'(","),
        48'(";"), 48'("("), 48'(")"), 48'("["),
        48'("]"), 48'("{"), 48'("}"), 48'("if"),
        48'("else"), 48'("do"), 48'("while"), 48'("for"),
        48'("const"), 48'("int"), 48'("char"), 48'("void"),
        48'("main"), 48'("return"), 48'("printf"), 48'("scanf")
    };

    // Character j (from the start) of entry k; zero past the entry's end.
    function automatic byte_t entry_char(input int k, input int j);
        int    len;
        byte_t c;
        len = int'(ENTRY_LEN[k]);
        c   = 8'h00;
        if (j < len)
        begin
            c = ENTRY_TEXT[k][8*(len-1-j) +: 8];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lltm_entry_match.sv
`default_nettype none

// Compares the leading bytes against every table entry; bit k set when entry k
// lies within the valid bytes and equals them.
module lltm_entry_match
    import lltm_pkg::*;
#(
    parameter int AVAIL_W = 3
)
(
    input  wire text_t              lead,
    input  wire logic [AVAIL_W-1:0] avail,
    output match_vec_t              hit
);

    always_comb
    begin
        logic ok;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            ok = (AVAIL_W'(ENTRY_LEN[k]) <= avail);
            for (int j = 0; j < MAX_ENTRY_LEN; j++)
            begin
                if (j < int'(ENTRY_LEN[k]))
                begin
                    if (lead[8*j +: 8] != entry_char(k, j))
                    begin
                        ok = 1'b0;
                    end
                end
            end
            hit[k] = ok;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lexer_longest_token_match_unit.sv
`default_nettype none

// Channel | Direction | Handshake           | Payload
// in      | sink      | in_valid / in_ready | window, avail
// out     | source    | out_valid/out_ready | found, token_id, match_len
//
// Four register stages: input capture, per-entry compare, per-length
// priority pick, longest-length select into the output register.
// One item per cycle sustained while out_ready is held; an input transfer reaches
// out_valid through the s1, s2, s3 and output registers in that order.
// Each stage holds while the one after it is full and stalled; ready ripples
// back through the stage valids, so nothing is dropped or repeated.
// Reset clears the stage valid bits only.

`include "lexer_longest_token_match_unit_assert.svh"

module lexer_longest_token_match_unit
    import lltm_pkg::*;
#(
    parameter int WINDOW_BYTES = 6,
    localparam int AVAIL_W     = $clog2(WINDOW_BYTES + 1)
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [8*WINDOW_BYTES-1:0] window,
    input  wire logic [AVAIL_W-1:0]        avail,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           found,
    output logic [ID_W-1:0]                token_id,
    output logic [LEN_W-1:0]               match_len
);

    // stage 1: captured bytes and clamped count
    logic               s1_valid_reg;
    text_t              s1_lead_reg;
    logic [AVAIL_W-1:0] s1_avail_reg;
    logic [AVAIL_W-1:0] avail_clamped;

    // stage 2: per-entry hits
    logic       s2_valid_reg;
    match_vec_t s2_hit_reg;
    match_vec_t hit_next;

    // stage 3: lowest hit index per entry length
    logic                     s3_valid_reg;
    logic [MAX_ENTRY_LEN-1:0] s3_any_reg;
    idx_t                     s3_idx_reg [MAX_ENTRY_LEN];
    logic [MAX_ENTRY_LEN-1:0] any_next;
    idx_t                     idx_next [MAX_ENTRY_LEN];

    // stage 4: output
    logic            out_valid_reg;
    logic            found_reg;
    logic [ID_W-1:0] token_id_reg;
    len_t            match_len_reg;
    logic            found_next;
    logic [ID_W-1:0] token_id_next;
    len_t            match_len_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic s4_ready;

    assign s4_ready = !out_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign avail_clamped = (avail > AVAIL_W'(WINDOW_BYTES)) ? AVAIL_W'(WINDOW_BYTES) : avail;

    lltm_entry_match #(
        .AVAIL_W (AVAIL_W)
    ) u_match (
        .lead  (s1_lead_reg),
        .avail (s1_avail_reg),
        .hit   (hit_next)
    );

    // lowest index wins among equal lengths
    always_comb
    begin
        for (int l = 0; l < MAX_ENTRY_LEN; l++)
        begin
            any_next[l] = 1'b0;
            idx_next[l] = '0;
            for (int k = NUM_ENTRIES - 1; k >= 0; k--)
            begin
                if (s2_hit_reg[k] && (int'(ENTRY_LEN[k]) == l + 1))
                begin
                    any_next[l] = 1'b1;
                    idx_next[l] = IDX_W'(k);
                end
            end
        end
    end

    always_comb
    begin
        found_next     = 1'b0;
        token_id_next  = '0;
        match_len_next = '0;
        for (int l = 0; l < MAX_ENTRY_LEN; l++)
        begin
            if (s3_any_reg[l])
            begin
                found_next     = 1'b1;
                token_id_next  = ID_W'(FIRST_ID) + ID_W'(s3_idx_reg[l]);
                match_len_next = LEN_W'(l + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_lead_reg  <= window[8*MAX_ENTRY_LEN-1:0];
            s1_avail_reg <= avail_clamped;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_hit_reg <= hit_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_any_reg <= any_next;
            s3_idx_reg <= idx_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            found_reg     <= found_next;
            token_id_reg  <= token_id_next;
            match_len_reg <= match_len_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign token_id  = token_id_reg;
    assign match_len = match_len_reg;

    `LLTM_ASSERT_SAME(a_none_zero, out_valid && !found, token_id == '0 && match_len == '0)
    `LLTM_ASSERT_SAME(a_found_range, out_valid && found,
        token_id >= ID_W'(FIRST_ID) && match_len != '0 && match_len <= LEN_W'(MAX_ENTRY_LEN))
    `LLTM_ASSERT_SAME(a_six_byte_ids, out_valid && found && match_len == LEN_W'(6),
        token_id == ID_W'(33) || token_id == ID_W'(34))
    `LLTM_ASSERT_NEXT(a_s1_load, in_valid && in_ready, s1_valid_reg)
    `LLTM_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !s3_ready,
        s2_valid_reg && $stable(s2_hit_reg))

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench
    import lltm_pkg::*;
;

    localparam int WIN_BYTES  = 6;
    localparam int WIN_W      = 8 * WIN_BYTES;
    localparam int RAND_ITEMS = 750;
    localparam int DRAIN_WAIT = 12;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] token_id;
        len_t            match_len;
    } lex_result_t;

    class token_scoreboard;
        string       words [NUM_ENTRIES];
        lex_result_t pending [$];
        int          mismatches;
        int          accepted;
        int          checked;
        int          misses;
        bit [63:0]   ids_seen;

        function new();
            words = '{"+", "-", "*", "/", "=", "<", "<=", ">",
                      ">=", "==", "!=", ",", ";", "(", ")", "[",
                      "]", "{", "}", "if", "else", "do", "while", "for",
                      "const", "int", "char", "void", "main", "return", "printf", "scanf"};
            mismatches = 0;
            accepted   = 0;
            checked    = 0;
            misses     = 0;
            ids_seen   = '0;
        endfunction

        // longest table word that is a prefix of the valid bytes; ties keep the lower id
        function lex_result_t longest_token(logic [WIN_W-1:0] w, logic [2:0] a);
            lex_result_t r;
            int          lim;
            int          wlen;
            bit          hit;
            lim = (int'(a) > WIN_BYTES) ? WIN_BYTES : int'(a);
            r   = '0;
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                wlen = words[k].len();
                if (wlen > int'(r.match_len) && wlen <= lim)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < wlen; i++)
                    begin
                        if (w[8*i +: 8] !== words[k][i])
                            hit = 1'b0;
                    end
                    if (hit)
                    begin
                        r.found     = 1'b1;
                        r.token_id  = ID_W'(FIRST_ID + k);
                        r.match_len = len_t'(wlen);
                    end
                end
            end
            return r;
        endfunction

        function void note_input(logic [WIN_W-1:0] w, logic [2:0] a);
            lex_result_t r;
            r = longest_token(w, a);
            pending.push_back(r);
            accepted++;
            if (r.found)
                ids_seen[r.token_id] = 1'b1;
            else
                misses++;
        endfunction

        function void check_result(logic f, logic [ID_W-1:0] id, len_t len);
            lex_result_t exp_r;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result found=%b id=%0d len=%0d",
                             $realtime, f, id, len);
                return;
            end
            exp_r = pending.pop_front();
            if (f !== exp_r.found || id !== exp_r.token_id || len !== exp_r.match_len)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp found=%b id=%0d len=%0d, got found=%b id=%0d len=%0d",
                             $realtime, exp_r.found, exp_r.token_id, exp_r.match_len,
                             f, id, len);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [WIN_W-1:0] window;
    logic [2:0]       avail;
    logic             out_valid;
    logic             out_ready;
    logic             found;
    logic [ID_W-1:0]  token_id;
    logic [LEN_W-1:0] match_len;

    token_scoreboard sb;
    int              cycles;
    bit              no_gaps;

    lexer_longest_token_match_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .window    (window),
        .avail     (avail),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .token_id  (token_id),
        .match_len (match_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb        = new();
        cycles    = 0;
        no_gaps   = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        window    = '0;
        avail     = '0;
        out_ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // transfers are sampled with pre-edge values; drivers update via NBA
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(found, token_id, match_len);
            if (in_valid && in_ready)
                sb.note_input(window, avail);
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WIN_W-1:0] rand_window();
        return WIN_W'({$urandom, $urandom});
    endfunction

    // token text in the low bytes, fill above it
    function automatic logic [WIN_W-1:0] pack_text(string s, logic [WIN_W-1:0] fill);
        logic [WIN_W-1:0] w;
        w = fill;
        for (int i = 0; i < s.len() && i < WIN_BYTES; i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    task automatic send_item(logic [WIN_W-1:0] w, logic [2:0] a);
        int gap;
        gap = no_gaps ? 0 : pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        window   <= w;
        avail    <= a;
        do @(posedge clk); while (!in_ready);
    endtask

    // mostly real tokens with varied tails and counts, some near misses and noise
    task automatic send_random_item();
        logic [WIN_W-1:0] w;
        logic [WIN_W-1:0] fill;
        logic [2:0]       a;
        string            s;
        int               r;
        int               t;
        int               pos;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            w = rand_window();
            a = 3'($urandom_range(0, 7));
        end
        else
        begin
            s = sb.words[$urandom_range(0, NUM_ENTRIES - 1)];
            t = $urandom_range(0, 2);
            fill = rand_window();
            if (t == 1)
                s = {s, sb.words[$urandom_range(0, NUM_ENTRIES - 1)]};
            else if (t == 2)
            begin
                for (int i = 0; i < WIN_BYTES; i++)
                    fill[8*i +: 8] = 8'("a") + 8'($urandom_range(0, 25));
            end
            w = pack_text(s, fill);
            if (r < 32)
            begin
                pos = $urandom_range(0, ((s.len() > WIN_BYTES) ? WIN_BYTES : s.len()) - 1);
                w[8*pos +: 8] ^= 8'(1 << $urandom_range(0, 7));
            end
            if ($urandom_range(0, 3) == 0)
                a = 3'($urandom_range(0, 7));
            else
                a = 3'($urandom_range((s.len() > 7) ? 7 : s.len(), 7));
        end
        send_item(w, a);
    endtask

    // receiver: ready stretches broken by stalls, sometimes long open windows
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (n) @(posedge clk);
            n = pick_idle();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin
        #1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, count clamping, truncation, overlapping operators
        send_item('0, 3'd0);
        send_item('1, 3'd7);
        send_item('1, 3'd6);
        send_item(pack_text("if", rand_window()), 3'd0);
        send_item(pack_text("printf", '0), 3'd7);
        send_item(pack_text("printf", '0), 3'd6);
        send_item(pack_text("printf", '0), 3'd5);
        send_item(pack_text("return", '0), 3'd6);
        send_item(pack_text("<=", '0), 3'd1);
        send_item(pack_text("<=", '1), 3'd2);
        send_item(pack_text(">=", '0), 3'd2);
        send_item(pack_text(">x", '0), 3'd2);
        send_item(pack_text("==", '0), 3'd2);
        send_item(pack_text("==", '0), 3'd1);
        send_item(pack_text("!=", '0), 3'd2);
        send_item(pack_text("!=", '0), 3'd1);
        send_item(pack_text("intx", rand_window()), 3'd6);
        send_item(pack_text("scanf", '0), 3'd4);
        send_item(pack_text("scanf", '1), 3'd5);
        send_item(pack_text("while", rand_window()), 3'd5);
        send_item(pack_text("const", '0), 3'd7);
        send_item(pack_text("else", rand_window()), 3'd4);
        send_item(pack_text("char", '0), 3'd3);
        send_item(pack_text("voidmain", '0), 3'd4);
        send_item(pack_text("if", rand_window()), 3'd2);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 60 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_random_item();
        end
        in_valid <= 1'b0;
        // let the monitor note the last transfer before polling the queue
        @(posedge clk);

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d windows in, %0d results checked, %0d with no token",
                 sb.accepted, sb.checked, sb.misses);
        $display("%0d of %0d table entries hit, %0d mismatches",
                 $countones(sb.ids_seen), NUM_ENTRIES, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
